@@ hdl/vs3_pkg.sv @@
// Shared types and constants for the vector scale-to-length pipeline.
package vs3_pkg;

    localparam int unsigned DW          = 32;
    localparam int unsigned NORM_STAGES = 5;
    localparam int unsigned SQRT_STAGES = 32;
    localparam int unsigned DIV_STAGES  = 31;
    // divider steps, one multiply stage, one round and clip stage
    localparam int unsigned LANE_STAGES = DIV_STAGES + 2;
    localparam int unsigned NUM_LANES   = 3;

    // per-item context that travels beside the length computation
    typedef struct packed {
        logic [NUM_LANES-1:0][DW-1:0] comp;
        logic [NUM_LANES-1:0][DW-1:0] cmag;
        logic [NUM_LANES-1:0]         cneg;
        logic [DW-1:0]                tmag;
        logic                         tneg;
        logic                         zero;
        logic [4:0]                   k;
    } ctx_t;

endpackage

@@ hdl/vs3_sqrt.sv @@
// Pipelined 64-bit integer square root, one result bit per stage.
module vs3_sqrt
(
    input  logic                clk,
    input  logic                en,
    input  logic [63:0]         s,
    input  vs3_pkg::ctx_t       ctx_in,
    output logic [31:0]         root,
    output vs3_pkg::ctx_t       ctx_out
);

    localparam int unsigned N = vs3_pkg::SQRT_STAGES;

    logic [63:0]   rem_p [0:N];
    logic [63:0]   res_p [0:N];
    vs3_pkg::ctx_t ctx_p [0:N];

    assign rem_p[0] = s;
    assign res_p[0] = '0;
    assign ctx_p[0] = ctx_in;

    // one trial subtraction per stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        assign trial = res_p[i] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_p[i] >= trial)
                begin
                    rem_p[i+1] <= rem_p[i] - trial;
                    res_p[i+1] <= (res_p[i] >> 1) + BIT;
                end
                else
                begin
                    rem_p[i+1] <= rem_p[i];
                    res_p[i+1] <= res_p[i] >> 1;
                end
                ctx_p[i+1] <= ctx_p[i];
            end
        end
    end

    assign root    = res_p[N][31:0];
    assign ctx_out = ctx_p[N];

endmodule

@@ hdl/vs3_lane.sv @@
// One component lane: ratio divide, scale by target, round and clip.
module vs3_lane
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] cmag,
    input  logic        cneg,
    input  logic [4:0]  k,
    input  logic [31:0] len,
    input  logic [31:0] tmag,
    input  logic        tneg,
    output logic [31:0] val,
    output logic        sat
);

    localparam int unsigned N = vs3_pkg::DIV_STAGES;

    logic [62:0] shifted;
    logic [31:0] rem_p  [0:N];
    logic [30:0] low_p  [0:N];
    logic [30:0] q_p    [0:N];
    logic [31:0] len_p  [0:N];
    logic [31:0] tmag_p [0:N];
    logic        neg_p  [0:N];

    logic [62:0] prod_reg;
    logic        prod_neg_reg;
    logic [63:0] rounded;
    logic [33:0] m;

    // split the numerator (cmag << (k + 30)) into a head below len and 31 low bits
    assign shifted  = 63'(cmag) << k;
    assign rem_p[0] = shifted[32:1];
    assign low_p[0] = {shifted[0], 30'd0};
    assign q_p[0]   = '0;
    assign len_p[0] = len;
    assign tmag_p[0] = tmag;
    assign neg_p[0] = cneg ^ tneg;

    // restoring division, one quotient bit per stage
    for (genvar i = 0; i < N; i++) begin : g_div
        logic [32:0] part;
        assign part = {rem_p[i], low_p[i][30]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (part >= {1'b0, len_p[i]})
                begin
                    rem_p[i+1] <= 32'(part - {1'b0, len_p[i]});
                    q_p[i+1]   <= {q_p[i][29:0], 1'b1};
                end
                else
                begin
                    rem_p[i+1] <= part[31:0];
                    q_p[i+1]   <= {q_p[i][29:0], 1'b0};
                end
                low_p[i+1]  <= {low_p[i][29:0], 1'b0};
                len_p[i+1]  <= len_p[i];
                tmag_p[i+1] <= tmag_p[i];
                neg_p[i+1]  <= neg_p[i];
            end
        end
    end

    // scale the ratio by the target magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= 63'(q_p[N]) * 63'(tmag_p[N]);
            prod_neg_reg <= neg_p[N];
        end
    end

    assign rounded = 64'(prod_reg) + (64'd1 << 29);
    assign m       = rounded[63:30];

    // round half away from zero, apply sign, clip to range
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (prod_neg_reg)
            begin
                if (m > 34'h0_8000_0000)
                begin
                    val <= 32'h8000_0000;
                    sat <= 1'b1;
                end
                else
                begin
                    val <= 32'd0 - m[31:0];
                    sat <= 1'b0;
                end
            end
            else
            begin
                if (m > 34'h0_7FFF_FFFF)
                begin
                    val <= 32'h7FFF_FFFF;
                    sat <= 1'b1;
                end
                else
                begin
                    val <= m[31:0];
                    sat <= 1'b0;
                end
            end
        end
    end

endmodule

@@ hdl/vector3_scale_to_length_core.sv @@
// Path from input accept to result valid: capture, squares, sum, 5 normalize
// stages, 32 square-root stages, 33 lane stages, merge register.
// Throughput: one item per cycle; the pipelined square root and the three
// pipelined lane dividers each take a new operand every cycle.
// The whole pipeline holds while a result waits untaken.
// Reset clears the stage valid bits and the output valid; payload is not reset.
module vector3_scale_to_length_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] comp_x,
    input  logic [31:0] comp_y,
    input  logic [31:0] comp_z,
    input  logic [31:0] target_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        scaled_ok,
    output logic        saturated
);

    localparam int unsigned NL    = vs3_pkg::NUM_LANES;
    localparam int unsigned NN    = vs3_pkg::NORM_STAGES;
    localparam int unsigned LD    = vs3_pkg::LANE_STAGES;
    localparam int unsigned DEPTH = 3 + NN + vs3_pkg::SQRT_STAGES + LD;

    logic              en;
    logic [DEPTH-1:0]  valid_reg;
    logic              out_valid_reg;

    logic [NL-1:0][31:0] comp_in;
    vs3_pkg::ctx_t       ctx1_reg, ctx2_reg, ctx3_reg;
    vs3_pkg::ctx_t       ctx3_next;
    logic [NL-1:0][63:0] sq_reg;
    logic [63:0]         sum_reg;

    logic [63:0]   norm_p [0:NN];
    vs3_pkg::ctx_t nctx_p [0:NN];

    logic [31:0]   root;
    vs3_pkg::ctx_t sctx;

    logic [NL-1:0][31:0] lane_val;
    logic [NL-1:0]       lane_sat;
    vs3_pkg::ctx_t       dctx_p [0:LD];

    logic [NL-1:0][31:0] out_reg;
    logic                ok_reg;
    logic                sat_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign comp_in  = {comp_z, comp_y, comp_x};

    // track which stages hold an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    // capture magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
            begin
                ctx1_reg.comp[i] <= comp_in[i];
                ctx1_reg.cneg[i] <= comp_in[i][31];
                ctx1_reg.cmag[i] <= comp_in[i][31] ? 32'd0 - comp_in[i] : comp_in[i];
            end
            ctx1_reg.tneg <= target_length[31];
            ctx1_reg.tmag <= target_length[31] ? 32'd0 - target_length : target_length;
            ctx1_reg.zero <= 1'b0;
            ctx1_reg.k    <= '0;
        end
    end

    // mark the zero vector beside the sum
    always_comb
    begin
        ctx3_next      = ctx2_reg;
        ctx3_next.zero = (sq_reg[0] | sq_reg[1] | sq_reg[2]) == 64'd0;
    end

    // square each magnitude, then sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
                sq_reg[i] <= 64'(ctx1_reg.cmag[i]) * 64'(ctx1_reg.cmag[i]);
            ctx2_reg <= ctx1_reg;
            sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            ctx3_reg <= ctx3_next;
        end
    end

    assign norm_p[0] = sum_reg;
    assign nctx_p[0] = ctx3_reg;

    // normalize the sum by even shifts until its top two bits are not both zero
    for (genvar j = 0; j < NN; j++) begin : g_norm
        localparam int unsigned SH = 32 >> j;
        localparam int unsigned KI = 16 >> j;

        logic [63:0]   norm_next;
        vs3_pkg::ctx_t nctx_next;

        always_comb
        begin
            norm_next = norm_p[j];
            nctx_next = nctx_p[j];
            if (norm_p[j][63 -: SH] == '0)
            begin
                norm_next   = norm_p[j] << SH;
                nctx_next.k = nctx_p[j].k + 5'(KI);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                norm_p[j+1] <= norm_next;
                nctx_p[j+1] <= nctx_next;
            end
        end
    end

    vs3_sqrt u_sqrt
    (
        .clk     (clk),
        .en      (en),
        .s       (norm_p[NN]),
        .ctx_in  (nctx_p[NN]),
        .root    (root),
        .ctx_out (sctx)
    );

    // one lane per component
    for (genvar i = 0; i < NL; i++) begin : g_lane
        vs3_lane u_lane
        (
            .clk  (clk),
            .en   (en),
            .cmag (sctx.cmag[i]),
            .cneg (sctx.cneg[i]),
            .k    (sctx.k),
            .len  (root),
            .tmag (sctx.tmag),
            .tneg (sctx.tneg),
            .val  (lane_val[i]),
            .sat  (lane_sat[i])
        );
    end

    // delay the context alongside the lanes
    assign dctx_p[0] = sctx;
    for (genvar i = 0; i < LD; i++) begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
                dctx_p[i+1] <= dctx_p[i];
        end
    end

    // merge lanes, pass zero vectors through
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dctx_p[LD].zero)
            begin
                out_reg <= dctx_p[LD].comp;
                ok_reg  <= 1'b0;
                sat_reg <= 1'b0;
            end
            else
            begin
                out_reg <= lane_val;
                ok_reg  <= 1'b1;
                sat_reg <= |lane_sat;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign scaled_ok = ok_reg;
    assign saturated = sat_reg;

    a_zero_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !scaled_ok |-> !saturated)
        else $error("saturation flagged on pass-through item");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (out_x == 32'h7FFF_FFFF) || (out_y == 32'h7FFF_FFFF) || (out_z == 32'h7FFF_FFFF))
        else $error("saturation flagged without a clipped component");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

endmodule

@@ dv/vector3_scale_to_length_core_test.sv @@
// Self-checking testbench for the vector scale-to-length pipeline.
module vector3_scale_to_length_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY     = 74;
    localparam longint      CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        ok;
        logic        sat;
    } scaled_vec_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] target_length;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        scaled_ok;
    logic        saturated;

    scaled_vec_t expected_vecs[$];
    int          fail_count;
    longint      cycle_count;
    bit          hold_off;
    bit          idle_en;

    vector3_scale_to_length_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
        .target_length(target_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .scaled_ok(scaled_ok), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // absolute value of a 32-bit two's complement word
    function automatic logic [63:0] abs32(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    // bitwise integer square root of a 64-bit value
    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= res + bitv)
            begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale one component by target / length with rounding and clipping
    function automatic logic [31:0] scale_one(logic [31:0] c, int k, logic [63:0] len,
                                              logic [63:0] tmag, logic tneg, ref logic sat);
        logic [127:0] num;
        logic [63:0]  r;
        logic [63:0]  m;
        num = {64'd0, abs32(c)} << (k + 30);
        r   = 64'(num / {64'd0, len});
        m   = (r * tmag + (64'd1 << 29)) >> 30;
        if (c[31] != tneg)
        begin
            if (m > 64'h8000_0000)
            begin
                m   = 64'h8000_0000;
                sat = 1'b1;
            end
            return 32'(64'h1_0000_0000 - m);
        end
        if (m > 64'h7FFF_FFFF)
        begin
            m   = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        return m[31:0];
    endfunction

    function automatic scaled_vec_t predict_scaled(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z, logic [31:0] t);
        scaled_vec_t e;
        logic [63:0] s;
        logic [63:0] len;
        logic [63:0] tmag;
        logic        sat;
        int          k;
        s = abs32(x) * abs32(x) + abs32(y) * abs32(y) + abs32(z) * abs32(z);
        if (s == 0)
        begin
            e = '{x, y, z, 1'b0, 1'b0};
            return e;
        end
        k = 0;
        while (s < (64'd1 << 62))
        begin
            s = s << 2;
            k++;
        end
        len  = int_sqrt(s);
        tmag = abs32(t);
        sat  = 1'b0;
        e.vx = scale_one(x, k, len, tmag, t[31], sat);
        e.vy = scale_one(y, k, len, tmag, t[31], sat);
        e.vz = scale_one(z, k, len, tmag, t[31], sat);
        e.ok  = 1'b1;
        e.sat = sat;
        return e;
    endfunction

    // offer one item, record its expectation at acceptance
    task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
        int gap;
        gap = idle_en ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        comp_x        <= x;
        comp_y        <= y;
        comp_z        <= z;
        target_length <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_vecs.push_back(predict_scaled(x, y, z, t));
    endtask

    // random component biased toward extremes and small values
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, long hold-off when requested
    initial
    begin
        int wait_cycles;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_cycles = idle_en ? $urandom_range(0, 19) : 0;
            if (wait_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        scaled_vec_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vecs.size() == 0)
            begin
                $error("result with no item pending");
                fail_count++;
            end
            else
            begin
                e = expected_vecs.pop_front();
                if (out_x !== e.vx)
                begin
                    $error("out_x expected %h actual %h", e.vx, out_x);
                    fail_count++;
                end
                if (out_y !== e.vy)
                begin
                    $error("out_y expected %h actual %h", e.vy, out_y);
                    fail_count++;
                end
                if (out_z !== e.vz)
                begin
                    $error("out_z expected %h actual %h", e.vz, out_z);
                    fail_count++;
                end
                if (scaled_ok !== e.ok)
                begin
                    $error("scaled_ok expected %b actual %b", e.ok, scaled_ok);
                    fail_count++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %b actual %b", e.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        send_vec(0, 0, 0, 32'h0001_0000);
        send_vec(0, 0, 0, 32'h8000_0000);
        send_vec(32'h0001_0000, 0, 0, 32'h0001_0000);
        send_vec(32'h0003_0000, 32'h0004_0000, 0, 32'h0001_0000);
        send_vec(1, 1, 1, 32'h0001_0000);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_vec(32'h0001_0000, 0, 0, 32'h8000_0000);
        send_vec(32'hFFFF_0000, 0, 0, 32'h8000_0000);
        send_vec(32'h8000_0000, 0, 0, 32'h8000_0000);
        send_vec(32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D, 0);
        send_vec(32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_vec(0, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF);
        send_vec(32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_vec(rand_word(), rand_word(), rand_word(),
                     ($urandom_range(0, 3) == 0) ? rand_word() : $urandom);
    endtask

    task automatic test_back_to_back(int count);
        idle_en = 1'b0;
        for (int i = 0; i < count; i++)
            send_vec($urandom, $urandom, $urandom, 32'h0001_0000);
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure(int count);
        idle_en  = 1'b0;
        hold_off = 1'b1;
        for (int i = 0; i < count; i++)
            send_vec(rand_word(), $urandom, rand_word(), $urandom);
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        comp_x        <= '0;
        comp_y        <= '0;
        comp_z        <= '0;
        target_length <= '0;
        fail_count    = 0;
        cycle_count   = 0;
        hold_off      = 1'b0;
        idle_en       = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_back_to_back(300);
        test_backpressure(200);
        test_random(300);
        in_valid <= 1'b0;
        // drain and let the pipeline settle
        while (expected_vecs.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/vs3_pkg.sv
hdl/vs3_sqrt.sv
hdl/vs3_lane.sv
hdl/vector3_scale_to_length_core.sv
dv/vector3_scale_to_length_core_test.sv
